// ===== rtl/assert_macros.svh =====
// Concurrent check helpers; sampled on clk, quiet while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ULU8_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ulu8 same-cycle check failed");

`define ULU8_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ulu8 next-cycle check failed");

`else

`define ULU8_ASSERT_IMP(label, ante, cons)

`define ULU8_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/ulu8_pkg.sv =====
`default_nettype none

package ulu8_pkg;

	localparam int unsigned CP_W    = 21;
	localparam int unsigned MAX_RES = 3;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       text_end;
	} in_item_t;

	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            last_of_text;
	} out_item_t;

	// Results of one request, item 0 leaves first.
	typedef struct packed {
		logic [1:0]                    count;
		out_item_t [MAX_RES-1:0]       items;
	} res_set_t;

	typedef struct packed {
		logic [CP_W-1:0] cp;
		logic [2:0]      adv;
	} dec_t;

	// Open sequence plus the incoming byte, entry 0 is the lead.
	typedef logic [3:0][7:0] seq_buf_t;

	function automatic logic [1:0] follow_need(input logic [7:0] c);
		logic [1:0] n;
		n = 2'd0;
		if (c[7] == 1'b0)
			n = 2'd0;
		else if ((c & 8'hE0) == 8'hC0)
			n = 2'd1;
		else if ((c & 8'hF0) == 8'hE0)
			n = 2'd2;
		else if ((c & 8'hF8) == 8'hF0)
			n = 2'd3;
		return n;
	endfunction

	// Decode the sequence that starts at pos; raw lead when it does not fit in len.
	function automatic dec_t decode_at(input seq_buf_t sb, input logic [2:0] len,
			input logic [2:0] pos);
		dec_t       d;
		logic [7:0] c;
		logic [1:0] n;
		logic [3:0] reach;
		logic [5:0] f1, f2, f3;
		c     = sb[pos[1:0]];
		n     = follow_need(c);
		reach = {1'b0, pos} + {2'b00, n};
		f1    = sb[pos[1:0] + 2'd1][5:0];
		f2    = sb[pos[1:0] + 2'd2][5:0];
		f3    = sb[pos[1:0] + 2'd3][5:0];
		if (n == 2'd0 || reach >= {1'b0, len}) begin
			d.cp  = {{(CP_W-8){1'b0}}, c};
			d.adv = 3'd1;
		end else if (n == 2'd1) begin
			d.cp  = {10'd0, c[4:0], f1};
			d.adv = 3'd2;
		end else if (n == 2'd2) begin
			d.cp  = {5'd0, c[3:0], f1, f2};
			d.adv = 3'd3;
		end else begin
			d.cp  = {c[2:0], f1, f2, f3};
			d.adv = 3'd4;
		end
		return d;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/ulu8_stream_if.sv =====
`default_nettype none

interface ulu8_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/ulu8_decode.sv =====
`default_nettype none

module ulu8_decode (
	input  logic [2:0][7:0]     held_bytes,
	input  logic [1:0]          held_count,
	input  ulu8_pkg::in_item_t  item,
	output ulu8_pkg::res_set_t  res_set,
	output logic [2:0][7:0]     next_bytes,
	output logic [1:0]          next_count
);
	import ulu8_pkg::*;

	seq_buf_t   sb;
	logic [2:0] len;
	dec_t       d0, d1, d2;
	logic [3:0] pos1, pos2;
	logic [1:0] n_end;

	always_comb begin
		sb[0] = held_bytes[0];
		sb[1] = held_bytes[1];
		sb[2] = held_bytes[2];
		sb[3] = 8'h00;
		sb[held_count] = item.in_byte;
		len = {1'b0, held_count} + 3'd1;

		// chain of up to three sequences for an end-of-text flush
		d0   = decode_at(sb, len, 3'd0);
		pos1 = {1'b0, d0.adv};
		d1   = decode_at(sb, len, pos1[2:0]);
		pos2 = pos1 + {1'b0, d1.adv};
		d2   = decode_at(sb, len, pos2[2:0]);

		n_end = 2'd1;
		if (pos1 < {1'b0, len}) begin
			n_end = 2'd2;
			if (pos2 < {1'b0, len})
				n_end = 2'd3;
		end

		res_set.items[0].code_point   = d0.cp;
		res_set.items[1].code_point   = d1.cp;
		res_set.items[2].code_point   = d2.cp;
		res_set.items[0].last_of_text = 1'b0;
		res_set.items[1].last_of_text = 1'b0;
		res_set.items[2].last_of_text = 1'b0;
		next_bytes = sb[2:0];

		if (item.text_end) begin
			res_set.count = n_end;
			res_set.items[n_end - 2'd1].last_of_text = 1'b1;
			next_count = 2'd0;
		end else if (len == {1'b0, follow_need(sb[0])} + 3'd1) begin
			res_set.count = 2'd1;
			next_count    = 2'd0;
		end else begin
			// hold the byte, sequence still open
			res_set.count = 2'd0;
			next_count    = len[1:0];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ulu8_drain.sv =====
`default_nettype none

module ulu8_drain (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  ulu8_pkg::res_set_t  res_set,
	output logic                free,
	ulu8_stream_if.source       out_ch
);
	import ulu8_pkg::*;

	out_item_t [MAX_RES-1:0] items_q;
	logic [1:0]              rem_q;
	logic [1:0]              rd_q;
	logic                    pop;

	assign out_ch.valid   = (rem_q != 2'd0);
	assign out_ch.payload = items_q[rd_q];
	assign pop            = out_ch.valid && out_ch.ready;
	assign free           = (rem_q == 2'd0) || (rem_q == 2'd1 && out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 2'd0;
			rd_q  <= 2'd0;
		end else if (load) begin
			rem_q <= res_set.count;
			rd_q  <= 2'd0;
		end else if (pop) begin
			rem_q <= rem_q - 2'd1;
			rd_q  <= rd_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			items_q <= res_set.items;
	end

endmodule

`default_nettype wire

// ===== rtl/lenient_utf8_decoder_top.sv =====
// Lenient UTF-8 decoder: one byte per request in, one code point per request out.
// byte_stream (sink) carries in_byte and text_end; code_stream (source) carries
// code_point and last_of_text. Both use valid/ready, a request moves when both
// are high at a rising edge of clk.
// A taken byte passes the input register, then the result register that drives
// code_stream, before its code point can leave. Throughput: one byte per cycle
// while the text runs and code_stream is ready; a byte that closes a sequence
// gives one code point, a byte that opens or extends one gives none. A text_end
// byte that cuts a sequence short flushes up to three code points, one per cycle
// from the result register, and the input side waits for them. Rate is set by
// the result register: one code point a cycle while code_stream is ready.
// arst_n low empties both registers and drops any open sequence; held bytes
// keep no reset value since they are read only under a nonzero count.
// When code_stream stalls, the result register holds, the input register
// fills, and byte_stream.ready falls until the result register drains.
`default_nettype none
`include "assert_macros.svh"

module lenient_utf8_decoder_top (
	input  logic           clk,
	input  logic           arst_n,
	ulu8_stream_if.sink    byte_stream,
	ulu8_stream_if.source  code_stream
);
	import ulu8_pkg::*;

	// input register stage
	in_item_t        item_s1;
	logic            valid_s1;
	logic            adv_s1;

	// open sequence
	logic [2:0][7:0] held_bytes_q;
	logic [1:0]      held_count_q;

	logic [2:0][7:0] next_bytes;
	logic [1:0]      next_count;
	res_set_t        res_set;
	logic            drain_free;

	// advance the staged byte once the result register can take its results
	assign adv_s1            = valid_s1 && drain_free;
	assign byte_stream.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_stream.valid && byte_stream.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_stream.valid && byte_stream.ready)
			item_s1 <= byte_stream.payload;
	end

	// commit the open sequence when the staged byte is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count_q <= 2'd0;
		end else if (adv_s1) begin
			held_count_q <= next_count;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1)
			held_bytes_q <= next_bytes;
	end

	ulu8_decode u_decode (
		.held_bytes (held_bytes_q),
		.held_count (held_count_q),
		.item       (item_s1),
		.res_set    (res_set),
		.next_bytes (next_bytes),
		.next_count (next_count)
	);

	ulu8_drain u_drain (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (adv_s1),
		.res_set (res_set),
		.free    (drain_free),
		.out_ch  (code_stream)
	);

	// a held sequence never outgrows what its lead asks for
	`ULU8_ASSERT_IMP(a_held_fits_lead, held_count_q != 2'd0,
		follow_need(held_bytes_q[0]) >= held_count_q)
	// a staged byte that cannot advance stays put
	`ULU8_ASSERT_NEXT(a_stage_holds, valid_s1 && !adv_s1,
		valid_s1 && $stable(item_s1))
	// the end of a text always closes the open sequence
	`ULU8_ASSERT_NEXT(a_end_clears, adv_s1 && item_s1.text_end, held_count_q == 2'd0)
	// only a flush gives more than one code point
	`ULU8_ASSERT_IMP(a_single_mid_text, adv_s1 && !item_s1.text_end,
		res_set.count == 2'd0 || res_set.count == 2'd1)

endmodule

`default_nettype wire
